// ----- hdl/men_pkg.sv -----
// ----------------------------------------------------------------------------
// men_pkg
// shared widths, codes and controller/datapath link types for the
// mutual exclusion node
// ----------------------------------------------------------------------------
`default_nettype none

package men_pkg;

  // defaults for the top level parameters
  localparam int NODES_DEF      = 8;
  localparam int CLOCK_BITS_DEF = 32;

  // fixed field widths
  localparam int KIND_W    = 2;
  localparam int PEER_W    = 3;
  localparam int TS_W      = 32;
  localparam int ACT_W     = 3;
  localparam int ENTRIES_W = 16;
  localparam int CNT_W     = 4;
  localparam int RESP_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_WANT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MSG   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEAVE = 2'd2;

  // result actions
  localparam logic [ACT_W-1:0] ACT_BCAST = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RESP  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEFER = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COUNT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ENTER = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LEFT  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_ERR   = 3'd6;

  // protocol phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_WAIT   = 2'd1;
  localparam logic [1:0] PH_INSIDE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CLOCK = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the input request into the item registers
    logic exec;     // perform the step and load its first result
    logic more;     // load the next follow-on result
  } men_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
    logic multi;      // the step under exec has follow-on results
    logic more_last;  // the follow-on result under more is the final one
  } men_sts_t;

endpackage

`default_nettype wire

// ----- hdl/men_ctrl.sv -----
// ----------------------------------------------------------------------------
// men_ctrl
// sequencer: accept a request, run its step, then issue follow-on results
// ----------------------------------------------------------------------------
`default_nettype none

module men_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire men_pkg::men_sts_t sts,
  output men_pkg::men_cmd_t      cmd
);
  import men_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_MORE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall    = !rst_n || (state_r != ST_IDLE);
  assign cmd.capture = in_valid && !in_stall;
  assign cmd.exec    = (state_r == ST_EXEC) && sts.out_free;
  assign cmd.more    = (state_r == ST_MORE) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.exec) state_nxt = sts.multi ? ST_MORE : ST_IDLE;
      end
      ST_MORE: begin
        if (cmd.more && sts.more_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC))
    else $error("captured request did not move to exec");

  a_last_follow_on_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.more && sts.more_last) |=> (state_r == ST_IDLE))
    else $error("final follow-on result did not return to idle");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && cmd.more) && !(cmd.capture && (cmd.exec || cmd.more)))
    else $error("overlapping controller commands");

endmodule

`default_nettype wire

// ----- hdl/men_dp.sv -----
// ----------------------------------------------------------------------------
// men_dp
// datapath: protocol state, lamport clock, deferred bitmap walk and the
// result register
// ----------------------------------------------------------------------------
`default_nettype none

module men_dp #(
  parameter int NODES      = men_pkg::NODES_DEF,
  parameter int CLOCK_BITS = men_pkg::CLOCK_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire men_pkg::men_cmd_t                 cmd,
  output men_pkg::men_sts_t                      sts,
  input  wire logic                              cfg_we,
  input  wire logic [men_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [men_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic [men_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [men_pkg::PEER_W-1:0]        in_peer,
  input  wire logic                              in_is_request,
  input  wire logic [men_pkg::TS_W-1:0]          in_timestamp,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [men_pkg::ACT_W-1:0]              out_action,
  output logic [men_pkg::PEER_W-1:0]             out_target,
  output logic [men_pkg::TS_W-1:0]               out_clock_value,
  output logic [men_pkg::ENTRIES_W-1:0]          out_entries,
  output logic                                   out_last
);
  import men_pkg::*;

  // bitmap width: peers above eight cannot be named
  localparam int DW = (NODES < 8) ? NODES : 8;
  // compare width covers both the clock and the 32-bit stamps
  localparam int CW = (CLOCK_BITS > TS_W) ? CLOCK_BITS : TS_W;
  localparam logic [CLOCK_BITS-1:0] CMAX   = {CLOCK_BITS{1'b1}};
  localparam logic [CW-1:0]         CMAX_X = CW'(CMAX);
  localparam logic [CNT_W-1:0]      DW_CNT = CNT_W'(DW);

  // configuration
  logic [PEER_W-1:0] node_id_r;
  logic [CNT_W-1:0]  node_count_r;

  // protocol state
  logic [CLOCK_BITS-1:0] clock_r, clock_nxt;
  logic [CLOCK_BITS-1:0] stamp_r, stamp_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [DW-1:0]         deferred_r, deferred_nxt;
  logic [RESP_W-1:0]     resp_r, resp_nxt;
  logic [ENTRIES_W-1:0]  entries_r, entries_nxt;
  logic [DW-1:0]         walk_r, walk_nxt;
  logic                  enter_pend_r, enter_pend_nxt;

  // item registers
  logic [KIND_W-1:0] kind_r;
  logic [PEER_W-1:0] peer_r;
  logic              is_req_r;
  logic [TS_W-1:0]   ts_r;

  // result register
  logic                 out_valid_r;
  logic [ACT_W-1:0]     out_action_r;
  logic [PEER_W-1:0]    out_target_r;
  logic [TS_W-1:0]      out_clock_r;
  logic [ENTRIES_W-1:0] out_entries_r;
  logic                 out_last_r;

  // step decode
  logic [CNT_W-1:0]      cnt;
  logic                  bad_sender;
  logic [CW-1:0]         clk_x, ts_x, stamp_x, max_x, cfg_x;
  logic [CLOCK_BITS-1:0] clk_bumped, clk_inc;
  logic                  grant;
  logic [RESP_W-1:0]     resp_inc;
  logic                  enter;
  logic [DW-1:0]         peer_mask;
  logic [DW-1:0]         scan_src, scan_low, scan_rest;
  logic [PEER_W-1:0]     scan_tgt;
  logic [CW-1:0]         clk_out_x;

  logic [ACT_W-1:0]  res_act;
  logic [PEER_W-1:0] res_tgt;
  logic              res_last;
  logic              multi;
  logic              load;

  always_comb begin
    if (node_count_r < CNT_W'(2)) begin
      cnt = CNT_W'(2);
    end else if (node_count_r > DW_CNT) begin
      cnt = DW_CNT;
    end else begin
      cnt = node_count_r;
    end
  end

  assign bad_sender = (peer_r == node_id_r) || ({1'b0, peer_r} >= cnt);

  assign clk_x   = CW'(clock_r);
  assign ts_x    = CW'(ts_r);
  assign stamp_x = CW'(stamp_r);
  assign max_x   = (clk_x > ts_x) ? clk_x : ts_x;
  assign clk_bumped = (max_x >= CMAX_X) ? CMAX : CLOCK_BITS'(max_x + CW'(1));
  assign clk_inc    = (clock_r == CMAX) ? clock_r : clock_r + CLOCK_BITS'(1);
  assign cfg_x      = CW'(cfg_wdata);

  always_comb begin
    unique case (phase_r)
      PH_IDLE: grant = 1'b1;
      PH_WAIT: grant = (ts_x < stamp_x) || ((ts_x == stamp_x) && (peer_r > node_id_r));
      default: grant = 1'b0;
    endcase
  end

  assign resp_inc = resp_r + RESP_W'(1);
  assign enter    = ({1'b0, resp_inc} >= (cnt - CNT_W'(1)));

  always_comb begin
    for (int i = 0; i < DW; i++) begin
      peer_mask[i] = (peer_r == PEER_W'(i));
    end
  end

  // lowest set bit of the bitmap being answered
  assign scan_src  = cmd.more ? walk_r : deferred_r;
  assign scan_low  = scan_src & (~scan_src + DW'(1));
  assign scan_rest = scan_src & ~scan_low;

  always_comb begin
    scan_tgt = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      if (scan_src[i]) scan_tgt = PEER_W'(i);
    end
  end

  always_comb begin
    clock_nxt      = clock_r;
    stamp_nxt      = stamp_r;
    phase_nxt      = phase_r;
    deferred_nxt   = deferred_r;
    resp_nxt       = resp_r;
    entries_nxt    = entries_r;
    walk_nxt       = walk_r;
    enter_pend_nxt = enter_pend_r;
    res_act        = ACT_ERR;
    res_tgt        = '0;
    res_last       = 1'b1;
    multi          = 1'b0;
    if (cmd.exec) begin
      unique case (kind_r)
        KIND_WANT: begin
          if (phase_r == PH_IDLE) begin
            stamp_nxt = clock_r;
            resp_nxt  = '0;
            phase_nxt = PH_WAIT;
            res_act   = ACT_BCAST;
          end
        end
        KIND_MSG: begin
          res_tgt = peer_r;
          if (bad_sender) begin
            res_act = ACT_ERR;
          end else if (is_req_r) begin
            clock_nxt = clk_bumped;
            if (grant) begin
              res_act = ACT_RESP;
            end else begin
              deferred_nxt = deferred_r | peer_mask;
              res_act      = ACT_DEFER;
            end
          end else if (phase_r == PH_WAIT) begin
            clock_nxt = clk_inc;
            resp_nxt  = resp_inc;
            res_act   = ACT_COUNT;
            res_tgt   = '0;
            if (enter) begin
              if (entries_r != {ENTRIES_W{1'b1}}) entries_nxt = entries_r + ENTRIES_W'(1);
              phase_nxt      = PH_INSIDE;
              enter_pend_nxt = 1'b1;
              multi          = 1'b1;
              res_last       = 1'b0;
            end
          end
        end
        KIND_LEAVE: begin
          if (phase_r == PH_INSIDE) begin
            deferred_nxt = '0;
            resp_nxt     = '0;
            phase_nxt    = PH_IDLE;
            if (deferred_r != '0) begin
              res_act  = ACT_RESP;
              res_tgt  = scan_tgt;
              walk_nxt = scan_rest;
              multi    = (scan_rest != '0);
              res_last = !multi;
            end else begin
              res_act = ACT_LEFT;
            end
          end
        end
        default: res_act = ACT_ERR;
      endcase
    end else if (cmd.more) begin
      if (enter_pend_r) begin
        enter_pend_nxt = 1'b0;
        res_act        = ACT_ENTER;
      end else begin
        res_act  = ACT_RESP;
        res_tgt  = scan_tgt;
        walk_nxt = scan_rest;
        res_last = (scan_rest == '0);
      end
    end
    // clock preset; the user must write it only while no request is in flight, the block does not enforce this
    if (cfg_we && (cfg_index == REG_INIT_CLOCK)) begin
      clock_nxt = (cfg_x > CMAX_X) ? CMAX : CLOCK_BITS'(cfg_x);
    end
  end

  assign load          = cmd.exec || cmd.more;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.multi     = multi;
  assign sts.more_last = enter_pend_r || (scan_rest == '0);
  assign clk_out_x     = CW'(clock_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      node_count_r <= CNT_W'(8);
      clock_r      <= '0;
      stamp_r      <= '0;
      phase_r      <= PH_IDLE;
      deferred_r   <= '0;
      resp_r       <= '0;
      entries_r    <= '0;
      walk_r       <= '0;
      enter_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_NODE_ID)) node_id_r <= cfg_wdata[PEER_W-1:0];
      if (cfg_we && (cfg_index == REG_NODE_COUNT)) node_count_r <= cfg_wdata[CNT_W-1:0];
      clock_r      <= clock_nxt;
      stamp_r      <= stamp_nxt;
      phase_r      <= phase_nxt;
      deferred_r   <= deferred_nxt;
      resp_r       <= resp_nxt;
      entries_r    <= entries_nxt;
      walk_r       <= walk_nxt;
      enter_pend_r <= enter_pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_kind;
      peer_r   <= in_peer;
      is_req_r <= in_is_request;
      ts_r     <= in_timestamp;
    end
    if (load) begin
      out_action_r  <= res_act;
      out_target_r  <= res_tgt;
      out_clock_r   <= clk_out_x[TS_W-1:0];
      out_entries_r <= entries_nxt;
      out_last_r    <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_target      = out_target_r;
  assign out_clock_value = out_clock_r;
  assign out_entries     = out_entries_r;
  assign out_last        = out_last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> sts.out_free)
    else $error("result loaded over a waiting result");

  a_idle_no_deferred: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (deferred_r == '0))
    else $error("deferred peers held while idle");

  a_enter_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    enter_pend_r |-> ((walk_r == '0) && (phase_r == PH_INSIDE)))
    else $error("entry pending alongside a leave walk");

endmodule

`default_nettype wire

// ----- hdl/mutual_exclusion_node_top.sv -----
// ----------------------------------------------------------------------------
// mutual_exclusion_node_top
// one node of ricart-agrawala mutual exclusion on a saturating lamport clock
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      to node    in_valid / in_stall  kind, peer, is_request, timestamp
//   out_     from node  out_valid / out_stall action, target, clock_value,
//                                            entries, last
//   cfg_     to node    cfg_we               cfg_index, cfg_wdata
//
// a request is first captured into the item registers, then its step runs and
// loads the first result into the output register once that register is free
// further results follow, one a cycle while out_stall allows: the entry after
// the final response, or one per deferred peer on leave, lowest set bit first
// a new request is taken once the last result is loaded, even while it waits
// reset is synchronous: clears clock, phase, bitmap and counts, node 0 of 8
// out_stall holds the output register and pauses the sequencer behind it
// ----------------------------------------------------------------------------
`default_nettype none

module mutual_exclusion_node_top #(
  parameter int NODES      = men_pkg::NODES_DEF,      // peers taking part at most
  parameter int CLOCK_BITS = men_pkg::CLOCK_BITS_DEF  // logical clock width
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [men_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [men_pkg::CFG_W-1:0]       cfg_wdata,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [men_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [men_pkg::PEER_W-1:0]      in_peer,
  input  wire logic                            in_is_request,
  input  wire logic [men_pkg::TS_W-1:0]        in_timestamp,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [men_pkg::ACT_W-1:0]            out_action,
  output logic [men_pkg::PEER_W-1:0]           out_target,
  output logic [men_pkg::TS_W-1:0]             out_clock_value,
  output logic [men_pkg::ENTRIES_W-1:0]        out_entries,
  output logic                                 out_last
);
  import men_pkg::*;

  // command and status link between sequencer and datapath
  men_cmd_t cmd;
  men_sts_t sts;

  // sequencer: owns the request handshake
  men_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: protocol state, clock arithmetic and the result register
  men_dp #(
    .NODES      (NODES),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_kind         (in_kind),
    .in_peer         (in_peer),
    .in_is_request   (in_is_request),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_target      (out_target),
    .out_clock_value (out_clock_value),
    .out_entries     (out_entries),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_mutual_exclusion_node_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mutual_exclusion_node_top
// self-checking bench for one ricart-agrawala node on a saturating lamport
// clock: a scripted opening covers the error paths, the stamp tie-break, the
// deferral bitmap and clock saturation, then protocol-shaped random traffic
// with noise runs under bursty requests, patterned output stalls and register
// changes, every result checked against a behavioural model of the node
// ----------------------------------------------------------------------------

module tb_mutual_exclusion_node_top;

  import men_pkg::*;

  // kind code the node does not define, answered with an error
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [TS_W-1:0]   CLOCK_TOP  = '1;
  localparam int MAX_NODES    = 8;
  localparam int SETTLE       = 4;     // cycles let pass before a register write
  localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int RANDOM_ITEMS = 460;

  // one request as offered on the input channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PEER_W-1:0] peer;
    logic              is_req;
    logic [TS_W-1:0]   ts;
  } node_request_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [ACT_W-1:0]     action;
    logic [PEER_W-1:0]    target;
    logic [TS_W-1:0]      clock_value;
    logic [ENTRIES_W-1:0] entries;
    logic                 last;
  } node_result_t;

  // opening script row: a register write or a request, with an optional
  // hand-typed action and clock for the first result it causes
  typedef struct packed {
    bit                is_cfg;
    logic [1:0]        code;     // kind for a request, register index for a write
    logic [PEER_W-1:0] peer;
    logic              is_req;
    logic [31:0]       value;    // timestamp or write data
    bit                typed;
    logic [ACT_W-1:0]  t_act;
    logic [TS_W-1:0]   t_clock;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [PEER_W-1:0]    in_peer = '0;
  logic                 in_is_request = 1'b0;
  logic [TS_W-1:0]      in_timestamp = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ACT_W-1:0]     out_action;
  logic [PEER_W-1:0]    out_target;
  logic [TS_W-1:0]      out_clock_value;
  logic [ENTRIES_W-1:0] out_entries;
  logic                 out_last;

  mutual_exclusion_node_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_peer         (in_peer),
    .in_is_request   (in_is_request),
    .in_timestamp    (in_timestamp),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_action      (out_action),
    .out_target      (out_target),
    .out_clock_value (out_clock_value),
    .out_entries     (out_entries),
    .out_last        (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioural model of the node: its own clock, phase, bitmap and registers
  // ---------------------------------------------------------------------------
  logic [TS_W-1:0]      nm_time     = '0;
  logic [1:0]           nm_phase    = PH_IDLE;
  logic [TS_W-1:0]      nm_stamp    = '0;
  logic [7:0]           nm_deferred = '0;
  logic [RESP_W-1:0]    nm_replies  = '0;
  logic [ENTRIES_W-1:0] nm_entries  = '0;
  logic [PEER_W-1:0]    nm_id       = '0;
  logic [CNT_W-1:0]     nm_count    = 4'd8;

  // results predicted and not yet seen, oldest first
  node_result_t awaited_results[$];

  int errors    = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_writes  = 0;
  int n_defers  = 0;
  bit dirty     = 0;   // requests taken since the last quiet point

  // nodes actually taking part: register clamped to 2..8
  function automatic int unsigned active_nodes();
    int unsigned c;
    c = 32'(nm_count);
    if (c < 2) c = 2;
    if (c > MAX_NODES) c = MAX_NODES;
    return c;
  endfunction

  task automatic post_result(input logic [ACT_W-1:0] act, input logic [PEER_W-1:0] tgt,
                             input logic [TS_W-1:0] clock_value);
    awaited_results.push_back({act, tgt, clock_value, nm_entries, 1'b0});
  endtask

  // lamport bump to max(clock, stamp) + 1, held at the top
  task automatic bump_clock(input logic [TS_W-1:0] ts);
    logic [TS_W-1:0] m;
    m = (nm_time > ts) ? nm_time : ts;
    nm_time = (m == CLOCK_TOP) ? CLOCK_TOP : m + 1'b1;
  endtask

  // advance the model by one accepted request and queue what it should produce
  task automatic step_node(input node_request_t rq);
    int unsigned quorum;
    bit grant;
    bit any;
    quorum = active_nodes();
    any = 0;
    case (rq.kind)
      KIND_WANT: begin
        if (nm_phase == PH_IDLE) begin
          nm_stamp   = nm_time;
          nm_replies = '0;
          nm_phase   = PH_WAIT;
          post_result(ACT_BCAST, '0, nm_stamp);
        end else begin
          post_result(ACT_ERR, '0, nm_time);
        end
      end
      KIND_MSG: begin
        if (rq.peer == nm_id || rq.peer >= quorum) begin
          // own id or a node outside the group: flagged, nothing changes
          post_result(ACT_ERR, rq.peer, nm_time);
        end else if (rq.is_req) begin
          if (nm_phase == PH_IDLE)
            grant = 1;
          else if (nm_phase == PH_WAIT)
            grant = (rq.ts < nm_stamp) || (rq.ts == nm_stamp && rq.peer > nm_id);
          else
            grant = 0;
          bump_clock(rq.ts);
          if (grant) begin
            post_result(ACT_RESP, rq.peer, nm_time);
          end else begin
            nm_deferred[rq.peer] = 1'b1;
            n_defers++;
            post_result(ACT_DEFER, rq.peer, nm_time);
          end
        end else if (nm_phase == PH_WAIT) begin
          // responses are only counted, so a repeated sender still counts
          if (nm_time != CLOCK_TOP) nm_time = nm_time + 1'b1;
          nm_replies = nm_replies + 1'b1;
          if (nm_replies >= quorum - 1) begin
            if (nm_entries != '1) nm_entries = nm_entries + 1'b1;
            nm_phase = PH_INSIDE;
            post_result(ACT_COUNT, '0, nm_time);
            post_result(ACT_ENTER, '0, nm_time);
          end else begin
            post_result(ACT_COUNT, '0, nm_time);
          end
        end else begin
          // stray response while idle or inside
          post_result(ACT_ERR, rq.peer, nm_time);
        end
      end
      KIND_LEAVE: begin
        if (nm_phase == PH_INSIDE) begin
          // deferred peers answered lowest id first
          for (int p = 0; p < 8; p++) begin
            if (nm_deferred[p]) begin
              post_result(ACT_RESP, PEER_W'(p), nm_time);
              any = 1;
            end
          end
          if (!any) post_result(ACT_LEFT, '0, nm_time);
          nm_deferred = '0;
          nm_replies  = '0;
          nm_phase    = PH_IDLE;
        end else begin
          post_result(ACT_ERR, '0, nm_time);
        end
      end
      default: post_result(ACT_ERR, '0, nm_time);
    endcase
    awaited_results[awaited_results.size()-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // output side: stall pattern and result checking
  // ---------------------------------------------------------------------------
  bit hold_ask = 0;      // raised by the request side to ask for the long hold
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  // stretches of free flow, light random stalls, a fixed one-in-three beat
  // and heavy stalls, with the single long hold-off on top
  always @(posedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(5, 60);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= (stall_tick % 3 == 0);
        default: out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  node_result_t due;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected nothing, got action %0d clock %0h",
                 $time, out_action, out_clock_value);
      end else begin
        due = awaited_results.pop_front();
        compare_field("action", 32'(due.action), 32'(out_action));
        compare_field("target", 32'(due.target), 32'(out_target));
        compare_field("clock_value", due.clock_value, out_clock_value);
        compare_field("entries", 32'(due.entries), 32'(out_entries));
        compare_field("last", 32'(due.last), 32'(out_last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic idle_bus();
    in_valid <= 1'b0;
  endtask

  // hold a request until taken, then update the model; valid stays up while
  // a burst lasts, otherwise a random gap follows
  task automatic offer(input node_request_t rq, input bit typed,
                       input logic [ACT_W-1:0] t_act, input logic [TS_W-1:0] t_clock);
    int base;
    cfg_we        <= 1'b0;
    in_valid      <= 1'b1;
    in_kind       <= rq.kind;
    in_peer       <= rq.peer;
    in_is_request <= rq.is_req;
    in_timestamp  <= rq.ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    base = awaited_results.size();
    step_node(rq);
    if (typed) begin
      awaited_results[base].action      = t_act;
      awaited_results[base].clock_value = t_clock;
    end
    n_items++;
    dirty = 1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 6);
    end
  endtask

  // drop valid, wait for every awaited result, then idle for tail cycles
  task automatic wait_quiet(input int tail);
    idle_bus();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
    dirty = 0;
  endtask

  // register write; enable is left up so writes can follow back to back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_NODE_ID:    nm_id    = value[PEER_W-1:0];
      REG_NODE_COUNT: nm_count = value[CNT_W-1:0];
      REG_INIT_CLOCK: nm_time  = value[TS_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  function automatic logic [TS_W-1:0] pick_stamp();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1, 2:    return nm_stamp;
      3, 4, 5: return nm_stamp + TS_W'($urandom_range(0, 4)) - 32'd2;
      default: return nm_time + TS_W'($urandom_range(0, 3));
    endcase
  endfunction

  // mostly well-formed traffic for the phase the node is in, some noise
  function automatic node_request_t pick_request();
    node_request_t rq;
    int unsigned quorum;
    int r;
    quorum = active_nodes();
    rq.kind   = KIND_MSG;
    rq.is_req = 1'b1;
    rq.ts     = pick_stamp();
    do rq.peer = PEER_W'($urandom_range(0, quorum - 1)); while (rq.peer == nm_id);
    r = $urandom_range(0, 99);
    if (r < 12) begin
      rq.kind   = KIND_W'($urandom_range(0, 3));
      rq.peer   = PEER_W'($urandom_range(0, 7));
      rq.is_req = 1'($urandom_range(0, 1));
      rq.ts     = $urandom;
    end else begin
      case (nm_phase)
        PH_IDLE:   if (r < 80) rq.kind = KIND_WANT;
        PH_WAIT:   if (r < 60) rq.is_req = 1'b0;
        PH_INSIDE: if (r < 65) rq.kind = KIND_LEAVE;
        default: ;
      endcase
    end
    return rq;
  endfunction

  // opening script, starting from reset values: node 0 of 8, clock 0
  script_row_t script [0:28] = '{
    // spare kind, leave while idle, stray response, message from own id
    '{1'b0, KIND_SPARE, 3'd0, 1'b0, 32'd0, 1'b1, ACT_ERR, 32'd0},
    '{1'b0, KIND_LEAVE, 3'd0, 1'b0, 32'd0, 1'b1, ACT_ERR, 32'd0},
    '{1'b0, KIND_MSG,   3'd1, 1'b0, 32'd0, 1'b1, ACT_ERR, 32'd0},
    '{1'b0, KIND_MSG,   3'd0, 1'b1, 32'd5, 1'b1, ACT_ERR, 32'd0},
    // four nodes: peer 5 is outside the group, idle request answered at once
    '{1'b1, REG_NODE_COUNT, 3'd0, 1'b0, 32'd4, 1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_MSG,   3'd5, 1'b1, 32'd0, 1'b1, ACT_ERR, 32'd0},
    '{1'b0, KIND_MSG,   3'd3, 1'b1, 32'hFFFF_FFF0, 1'b1, ACT_RESP, 32'hFFFF_FFF1},
    // full round from clock 10: tie granted to the larger id, later stamp
    // deferred, repeated response, request while inside, ascending answers
    '{1'b1, REG_INIT_CLOCK, 3'd0, 1'b0, 32'd10, 1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_WANT,  3'd0, 1'b0, 32'd0,  1'b1, ACT_BCAST, 32'd10},
    '{1'b0, KIND_WANT,  3'd0, 1'b0, 32'd0,  1'b1, ACT_ERR,   32'd10},
    '{1'b0, KIND_MSG,   3'd1, 1'b1, 32'd10, 1'b1, ACT_RESP,  32'd11},
    '{1'b0, KIND_MSG,   3'd2, 1'b1, 32'd20, 1'b1, ACT_DEFER, 32'd21},
    '{1'b0, KIND_MSG,   3'd1, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_MSG,   3'd1, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_MSG,   3'd3, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_MSG,   3'd3, 1'b1, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_WANT,  3'd0, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_LEAVE, 3'd0, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    // two nodes: one response enters, leave with nothing deferred
    '{1'b1, REG_NODE_COUNT, 3'd0, 1'b0, 32'd2, 1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_WANT,  3'd0, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_MSG,   3'd1, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_LEAVE, 3'd0, 1'b0, 32'd0,  1'b0, ACT_BCAST, 32'd0},
    // node 7, count above range, clock at the top: saturation, tie withheld from
    // a smaller id, leave out of turn
    '{1'b1, REG_NODE_ID,    3'd0, 1'b0, 32'd7,  1'b0, ACT_BCAST, 32'd0},
    '{1'b1, REG_NODE_COUNT, 3'd0, 1'b0, 32'd15, 1'b0, ACT_BCAST, 32'd0},
    '{1'b1, REG_INIT_CLOCK, 3'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, ACT_BCAST, 32'd0},
    '{1'b0, KIND_WANT,  3'd0, 1'b0, 32'd0, 1'b1, ACT_BCAST, 32'hFFFF_FFFF},
    '{1'b0, KIND_MSG,   3'd6, 1'b1, 32'd0, 1'b1, ACT_RESP,  32'hFFFF_FFFF},
    '{1'b0, KIND_MSG,   3'd3, 1'b1, 32'hFFFF_FFFF, 1'b1, ACT_DEFER, 32'hFFFF_FFFF},
    '{1'b0, KIND_LEAVE, 3'd0, 1'b0, 32'd0, 1'b1, ACT_ERR, 32'hFFFF_FFFF}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) begin
      if (script[r].is_cfg) begin
        if (dirty) wait_quiet(SETTLE);
        write_reg(script[r].code, script[r].value);
      end else begin
        offer({script[r].code, script[r].peer, script[r].is_req, script[r].value},
              script[r].typed, script[r].t_act, script[r].t_clock);
      end
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // new node identity, group size and clock now and then
      if (i % 70 == 69) begin
        wait_quiet(SETTLE);
        write_reg(REG_NODE_ID, CFG_W'($urandom_range(0, 7)));
        write_reg(REG_NODE_COUNT, ($urandom_range(0, 9) == 0) ?
                  CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(2, 8)));
        case ($urandom_range(0, 5))
          0:       write_reg(REG_INIT_CLOCK, '1);
          1:       write_reg(REG_INIT_CLOCK, 32'hFFFF_FFFF - $urandom_range(0, 20));
          2:       write_reg(REG_INIT_CLOCK, $urandom);
          default: write_reg(REG_INIT_CLOCK, CFG_W'($urandom_range(0, 1000)));
        endcase
      end
      // long receiver hold-off while requests keep coming back to back
      if (i == 150) begin
        hold_ask   = 1;
        burst_left = 16;
      end
      // pause until the node has answered everything
      if (i == 300) wait_quiet(1);
      offer(pick_request(), 1'b0, ACT_BCAST, '0);
    end

    wait_quiet(20);
    $display("run covered %0d requests, %0d results checked, %0d register writes",
             n_items, n_results, n_writes);
    $display("node reached %0d critical section entries with %0d deferrals",
             nm_entries, n_defers);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/men_pkg.sv
hdl/men_ctrl.sv
hdl/men_dp.sv
hdl/mutual_exclusion_node_top.sv
tb/sv/tb_mutual_exclusion_node_top.sv
